### src/sm2_der_pkg.sv
// ----------------------------------------------------------------------------
// SM2 DER stripper package
// Status codes and DER constants shared by the stripper core.
// ----------------------------------------------------------------------------
package sm2_der_pkg;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_TAG      = 3'd1,
		ST_BAD_LEN_FORM = 3'd2,
		ST_BAD_ELEMENT  = 3'd3,
		ST_LEN_MISMATCH = 3'd4
	} status_t;

	localparam logic [7:0] TAG_SEQUENCE = 8'h30;
	localparam logic [7:0] LEN_LONG     = 8'h80;
	localparam int         FIXED_FIELDS = 3;

endpackage

### src/sm2_ciphertext_der_stripper_core.sv
// ----------------------------------------------------------------------------
// SM2 ciphertext DER stripper core
// Parses a DER SEQUENCE { C1x, C1y, hash, C2 } one byte per transfer and
// emits C1x, C1y and hash as FIELD_BYTES bytes each, then the C2 bytes.
// ----------------------------------------------------------------------------
// Each byte passes through the input register, the result generator and the output register.
// Throughput: one byte per cycle while the result generator is free and the
//   output is not stalled; a short fixed-field length byte causes FIELD_BYTES - len
//   results, sent one per cycle by the result generator while result_stall is low,
//   and holds the input while more than one of them remains to be sent.
// Reset: arst_n clears all control state; the parser also returns to the outer tag after every final byte.
module sm2_ciphertext_der_stripper_core #(
	parameter int FIELD_BYTES   = 32,
	parameter int MAX_LEN_BYTES = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       is_last,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       run_last,
	output logic       done_res,
	output logic [2:0] status,
	output logic [7:0] payload_count
);

	localparam int PadW = $clog2(FIELD_BYTES + 1);
	localparam int LenW = 8 * MAX_LEN_BYTES;
	localparam int LbW  = $clog2(MAX_LEN_BYTES + 1);

	typedef enum logic [3:0] {
		PH_OUTER_TAG = 4'd0,
		PH_OUTER_LEN = 4'd1,
		PH_OUTER_EXT = 4'd2,
		PH_EL_TAG    = 4'd3,
		PH_EL_LEN    = 4'd4,
		PH_EL_DROP   = 4'd5,
		PH_EL_BODY   = 4'd6,
		PH_DONE      = 4'd7,
		PH_ERROR     = 4'd8
	} phase_t;

	// parser state
	phase_t               phase_q;
	logic [LbW-1:0]       olen_left_q;
	logic [LenW-1:0]      olen_q;
	logic [LenW-1:0]      seen_q;
	logic [1:0]           eidx_q;
	logic [7:0]           eleft_q;
	sm2_der_pkg::status_t err_q;
	logic [7:0]           ecnt_q;

	// input register
	logic                 v_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;

	// result generator
	logic [PadW-1:0]      gen_cnt_q;
	logic [7:0]           gen_byte_q;
	logic                 gen_bit_q;
	logic                 gen_done_q;
	sm2_der_pkg::status_t gen_status_q;
	logic [7:0]           gen_count_q;

	// output register
	logic                 out_v_q;
	logic [7:0]           out_byte_q;
	logic                 out_bit_q;
	logic                 out_last_q;
	logic                 out_done_q;
	logic [2:0]           out_status_q;
	logic [7:0]           out_count_q;

	// handshake chain
	logic out_take, out_free, gen_emit, gen_free, step_fire, data_take;

	assign out_take   = out_v_q & ~result_stall;
	assign out_free   = ~out_v_q | out_take;
	assign gen_emit   = (gen_cnt_q != '0) & out_free;
	assign gen_free   = (gen_cnt_q == '0) | ((gen_cnt_q == PadW'(1)) & out_free);
	assign step_fire  = v_s1 & gen_free;
	assign data_stall = v_s1 & ~gen_free;
	assign data_take  = data_valid & ~data_stall;

	// next parser state for the item in the input register
	phase_t               ph_n;
	logic [LbW-1:0]       olen_left_n;
	logic [LenW-1:0]      olen_n;
	logic [LenW-1:0]      seen_n;
	logic [1:0]           eidx_n;
	logic [7:0]           eleft_n;
	sm2_der_pkg::status_t err_n;
	logic [7:0]           ecnt_n;
	logic [PadW-1:0]      res_n;
	logic [7:0]           rbyte_n;
	logic                 rbit_n;
	sm2_der_pkg::status_t st_n;
	logic [7:0]           ecnt_res;
	logic [8:0]           ecnt_sum;
	logic [PadW-1:0]      pad_len;

	always_comb begin
		ph_n        = phase_q;
		olen_left_n = olen_left_q;
		olen_n      = olen_q;
		seen_n      = seen_q;
		eidx_n      = eidx_q;
		eleft_n     = eleft_q;
		err_n       = err_q;
		ecnt_n      = ecnt_q;
		res_n       = '0;
		rbyte_n     = 8'h00;
		rbit_n      = 1'b0;
		pad_len     = '0;
		ecnt_sum    = 9'd0;

		// count content bytes against the declared outer length
		if (phase_q >= PH_EL_TAG && phase_q <= PH_DONE) begin
			if (seen_q >= olen_q) begin
				err_n = sm2_der_pkg::ST_LEN_MISMATCH;
				ph_n  = PH_ERROR;
			end else begin
				seen_n = seen_q + LenW'(1);
			end
		end

		case (ph_n)
			PH_OUTER_TAG: begin
				if (byte_s1 != sm2_der_pkg::TAG_SEQUENCE) begin
					err_n = sm2_der_pkg::ST_BAD_TAG;
					ph_n  = PH_ERROR;
				end else begin
					ph_n = PH_OUTER_LEN;
				end
			end
			PH_OUTER_LEN: begin
				if (byte_s1 < sm2_der_pkg::LEN_LONG) begin
					olen_n = LenW'(byte_s1);
					eidx_n = 2'd0;
					ph_n   = PH_EL_TAG;
				end else if (byte_s1[6:0] == 7'd0 || byte_s1[6:0] > 7'(MAX_LEN_BYTES)) begin
					err_n = sm2_der_pkg::ST_BAD_LEN_FORM;
					ph_n  = PH_ERROR;
				end else begin
					olen_left_n = LbW'(byte_s1[6:0]);
					olen_n      = '0;
					ph_n        = PH_OUTER_EXT;
				end
			end
			PH_OUTER_EXT: begin
				olen_n = LenW'({olen_q, byte_s1});
				if (olen_left_q != '0)
					olen_left_n = olen_left_q - LbW'(1);
				if (olen_left_n == '0) begin
					eidx_n = 2'd0;
					ph_n   = PH_EL_TAG;
				end
			end
			PH_EL_TAG: begin
				ph_n = PH_EL_LEN;
			end
			PH_EL_LEN: begin
				if (eidx_q < 2'(sm2_der_pkg::FIXED_FIELDS)) begin
					if (byte_s1 > 8'(FIELD_BYTES + 1)) begin
						err_n = sm2_der_pkg::ST_BAD_ELEMENT;
						ph_n  = PH_ERROR;
					end else if (byte_s1 == 8'(FIELD_BYTES + 1)) begin
						ph_n = PH_EL_DROP;
					end else begin
						// left-pad a short field with zeros
						if (byte_s1 < 8'(FIELD_BYTES))
							pad_len = PadW'(FIELD_BYTES) - PadW'(byte_s1);
						res_n    = pad_len;
						rbit_n   = 1'b1;
						ecnt_sum = 9'(ecnt_q) + 9'(pad_len);
						ecnt_n   = ecnt_sum[8] ? 8'hFF : ecnt_sum[7:0];
						if (byte_s1 == 8'h00) begin
							eidx_n = eidx_q + 2'd1;
							ph_n   = PH_EL_TAG;
						end else begin
							eleft_n = byte_s1;
							ph_n    = PH_EL_BODY;
						end
					end
				end else begin
					if (byte_s1 >= sm2_der_pkg::LEN_LONG) begin
						err_n = sm2_der_pkg::ST_BAD_ELEMENT;
						ph_n  = PH_ERROR;
					end else if (byte_s1 == 8'h00) begin
						ph_n = PH_DONE;
					end else begin
						eleft_n = byte_s1;
						ph_n    = PH_EL_BODY;
					end
				end
			end
			PH_EL_DROP: begin
				eleft_n = 8'(FIELD_BYTES);
				ph_n    = PH_EL_BODY;
			end
			PH_EL_BODY: begin
				res_n   = PadW'(1);
				rbyte_n = byte_s1;
				rbit_n  = 1'b1;
				if (ecnt_q != 8'hFF)
					ecnt_n = ecnt_q + 8'd1;
				if (eleft_q != 8'd0)
					eleft_n = eleft_q - 8'd1;
				if (eleft_n == 8'd0) begin
					if (eidx_q >= 2'(sm2_der_pkg::FIXED_FIELDS)) begin
						ph_n = PH_DONE;
					end else begin
						eidx_n = eidx_q + 2'd1;
						ph_n   = PH_EL_TAG;
					end
				end
			end
			default: begin
			end
		endcase

		if (err_n != sm2_der_pkg::ST_OK)
			st_n = err_n;
		else if (ph_n < PH_EL_TAG || seen_n != olen_n)
			st_n = sm2_der_pkg::ST_LEN_MISMATCH;
		else if (ph_n != PH_DONE)
			st_n = sm2_der_pkg::ST_BAD_ELEMENT;
		else
			st_n = sm2_der_pkg::ST_OK;

		ecnt_res = ecnt_n;

		if (last_s1) begin
			// the final byte always yields at least one result, a filler if nothing else
			if (res_n == '0) begin
				res_n   = PadW'(1);
				rbyte_n = 8'h00;
				rbit_n  = 1'b0;
			end
			ph_n        = PH_OUTER_TAG;
			olen_left_n = '0;
			olen_n      = '0;
			seen_n      = '0;
			eidx_n      = 2'd0;
			eleft_n     = 8'd0;
			err_n       = sm2_der_pkg::ST_OK;
			ecnt_n      = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_OUTER_TAG;
			olen_left_q  <= '0;
			olen_q       <= '0;
			seen_q       <= '0;
			eidx_q       <= 2'd0;
			eleft_q      <= 8'd0;
			err_q        <= sm2_der_pkg::ST_OK;
			ecnt_q       <= 8'd0;
			v_s1         <= 1'b0;
			byte_s1      <= 8'h00;
			last_s1      <= 1'b0;
			gen_cnt_q    <= '0;
			gen_byte_q   <= 8'h00;
			gen_bit_q    <= 1'b0;
			gen_done_q   <= 1'b0;
			gen_status_q <= sm2_der_pkg::ST_OK;
			gen_count_q  <= 8'd0;
			out_v_q      <= 1'b0;
			out_byte_q   <= 8'h00;
			out_bit_q    <= 1'b0;
			out_last_q   <= 1'b0;
			out_done_q   <= 1'b0;
			out_status_q <= 3'd0;
			out_count_q  <= 8'd0;
		end else begin
			// input register
			if (data_take) begin
				v_s1    <= 1'b1;
				byte_s1 <= data_byte;
				last_s1 <= is_last;
			end else if (step_fire) begin
				v_s1 <= 1'b0;
			end

			// advance the parser and load the generator
			if (step_fire) begin
				phase_q      <= ph_n;
				olen_left_q  <= olen_left_n;
				olen_q       <= olen_n;
				seen_q       <= seen_n;
				eidx_q       <= eidx_n;
				eleft_q      <= eleft_n;
				err_q        <= err_n;
				ecnt_q       <= ecnt_n;
				gen_cnt_q    <= res_n;
				gen_byte_q   <= rbyte_n;
				gen_bit_q    <= rbit_n;
				gen_done_q   <= last_s1;
				gen_status_q <= st_n;
				gen_count_q  <= ecnt_res;
			end else if (gen_emit) begin
				gen_cnt_q <= gen_cnt_q - PadW'(1);
			end

			// output register: one result per transfer
			if (gen_emit) begin
				out_v_q      <= 1'b1;
				out_byte_q   <= gen_byte_q;
				out_bit_q    <= gen_bit_q;
				out_last_q   <= (gen_cnt_q == PadW'(1));
				out_done_q   <= gen_done_q & (gen_cnt_q == PadW'(1));
				out_status_q <= (gen_done_q & (gen_cnt_q == PadW'(1))) ? gen_status_q : 3'd0;
				out_count_q  <= (gen_done_q & (gen_cnt_q == PadW'(1))) ? gen_count_q : 8'd0;
			end else if (out_take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign result_valid  = out_v_q;
	assign out_byte      = out_byte_q;
	assign out_valid     = out_bit_q;
	assign run_last      = out_last_q;
	assign done_res      = out_done_q;
	assign status        = out_status_q;
	assign payload_count = out_count_q;

`ifndef SYNTH
	a_done_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && done_res |-> run_last)
		else $error("done_res without run_last");

	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !done_res |-> status == 3'd0 && payload_count == 8'd0)
		else $error("status or count outside final result");

	a_stall_when_padding: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && gen_cnt_q > PadW'(1) |-> data_stall)
		else $error("input not held while generator busy");

	a_gen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gen_cnt_q <= PadW'(FIELD_BYTES))
		else $error("generator count beyond field size");
`endif

endmodule
